/* design/iair_pkg.sv */
package iair_pkg;

    localparam int CMDW  = 2;
    localparam int IDXW  = 6;
    localparam int WORDW = 32;
    localparam int POSW  = 5;
    localparam int STATW = 2;

    localparam logic [CMDW-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMDW-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMDW-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STATW-1:0] STAT_OK    = 2'd0;
    localparam logic [STATW-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATW-1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [CMDW-1:0]         cmd;
        logic [IDXW-1:0]         index;
        logic signed [WORDW-1:0] value;
    } in_t;

    typedef struct packed {
        logic signed [WORDW-1:0] word;
        logic [POSW-1:0]         position;
        logic                    last;
        logic [STATW-1:0]        status;
    } out_t;

    typedef struct packed {
        logic [1:0] occ;
        logic       pop;
    } oq_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PUT,
        ST_READ
    } seq_state_t;

endpackage

/* design/iair_mem.sv */
module iair_mem #(
    parameter int DEPTH = 32
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic signed [iair_pkg::WORDW-1:0] wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic signed [iair_pkg::WORDW-1:0] rdata
);
    import iair_pkg::*;

    logic signed [WORDW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/iair_outq.sv */
module iair_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  iair_pkg::out_t     push_data,
    output logic               m_valid,
    input  logic               m_ready,
    output iair_pkg::out_t     m_data,
    output iair_pkg::oq_stat_t stat
);
    import iair_pkg::*;

    logic [1:0] occ_reg, occ_next;
    out_t       ent0_reg, ent0_next;
    out_t       ent1_reg, ent1_next;
    logic       pop;

    assign m_valid  = (occ_reg != 2'd0);
    assign m_data   = ent0_reg;
    assign pop      = m_valid && m_ready;
    assign stat.occ = occ_reg;
    assign stat.pop = pop;

    always_comb begin
        occ_next  = occ_reg;
        ent0_next = ent0_reg;
        ent1_next = ent1_reg;
        if (pop) begin
            ent0_next = ent1_reg;
            occ_next  = occ_reg - 2'd1;
        end
        if (push) begin
            if (occ_next == 2'd0) begin
                ent0_next = push_data;
            end else begin
                ent1_next = push_data;
            end
            occ_next = occ_next + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 2'd0;
        end else begin
            occ_reg <= occ_next;
        end
        ent0_reg <= ent0_next;
        ent1_reg <= ent1_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg != 2'd3)
        else $error("output queue count out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !(occ_reg == 2'd2 && !pop))
        else $error("push into a full output queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (occ_reg == 2'd2 && !pop && !push) |=> (occ_reg == 2'd2 && $stable(ent1_reg)))
        else $error("held beat lost from output queue");

endmodule

/* design/iair_seq.sv */
module iair_seq #(
    parameter int DEPTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  iair_pkg::in_t                     s_data,
    output logic                              mem_we,
    output logic [$clog2(DEPTH)-1:0]          mem_waddr,
    output logic signed [iair_pkg::WORDW-1:0] mem_wdata,
    output logic                              mem_re,
    output logic [$clog2(DEPTH)-1:0]          mem_raddr,
    input  logic signed [iair_pkg::WORDW-1:0] mem_rdata,
    input  iair_pkg::oq_stat_t                oq_stat,
    output logic                              push,
    output iair_pkg::out_t                    push_data
);
    import iair_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > IDXW) ? CW : IDXW;

    seq_state_t state_reg, state_next;

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]          rptr_reg, rptr_next;
    logic [AW-1:0]          idx_reg, idx_next;
    logic signed [WORDW-1:0] val_reg, val_next;
    logic                   ins_reg, ins_next;
    logic                   sh_pend_reg, sh_pend_next;
    logic [AW-1:0]          sh_addr_reg, sh_addr_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [AW-1:0]          rd_pos_reg, rd_pos_next;
    logic                   rd_last_reg, rd_last_next;

    logic            acc;
    logic [CMPW-1:0] idx_w, cnt_w;
    logic            full;
    logic            err_full, err_range;
    logic            go_shift, go_put;
    logic            shift_done;
    logic            put_ready;
    logic            rd_issue, rd_is_last;
    logic [2:0]      oq_level;

    assign s_ready = (state_reg == ST_IDLE) && !rd_pend_reg && (oq_stat.occ != 2'd2);
    assign acc     = s_valid && s_ready;
    assign idx_w   = CMPW'(s_data.index);
    assign cnt_w   = CMPW'(cnt_reg);
    assign full    = (cnt_reg >= CW'(DEPTH));

    // classify the incoming beat
    always_comb begin
        err_full  = 1'b0;
        err_range = 1'b0;
        go_shift  = 1'b0;
        go_put    = 1'b0;
        case (s_data.cmd)
            CMD_APPEND: begin
                err_full = full;
            end
            CMD_INSERT: begin
                if (full) begin
                    err_full = 1'b1;
                end else if (idx_w > cnt_w) begin
                    err_range = 1'b1;
                end else if (idx_w == cnt_w) begin
                    go_put = 1'b1;
                end else begin
                    go_shift = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (idx_w >= cnt_w) begin
                    err_range = 1'b1;
                end else if (idx_w + CMPW'(1) == cnt_w) begin
                    go_put = 1'b1;
                end else begin
                    go_shift = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign shift_done = ins_reg ? (rptr_reg == idx_reg)
                                : (rptr_reg == AW'(cnt_reg - CW'(1)));
    assign put_ready  = !sh_pend_reg;
    assign oq_level   = 3'(oq_stat.occ) + 3'(rd_pend_reg) - 3'(oq_stat.pop);
    assign rd_issue   = (state_reg == ST_READ) && (oq_level < 3'd2);
    assign rd_is_last = (CW'(rptr_reg) == cnt_reg - CW'(1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (acc && go_shift) begin
                    state_next = ST_SHIFT;
                end else if (acc && go_put) begin
                    state_next = ST_PUT;
                end
            end
            ST_SHIFT: begin
                if (shift_done) begin
                    state_next = ST_PUT;
                end
            end
            ST_PUT: begin
                if (put_ready) begin
                    // a remove of the only word leaves nothing to read out
                    if (!ins_reg && cnt_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                if (rd_issue && rd_is_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cnt_next     = cnt_reg;
        rptr_next    = rptr_reg;
        idx_next     = idx_reg;
        val_next     = val_reg;
        ins_next     = ins_reg;
        sh_pend_next = 1'b0;
        sh_addr_next = sh_addr_reg;
        rd_pend_next = 1'b0;
        rd_pos_next  = rd_pos_reg;
        rd_last_next = rd_last_reg;
        mem_re       = 1'b0;
        mem_raddr    = rptr_reg;
        // shifted word lands in the cycle after its read
        mem_we       = sh_pend_reg;
        mem_waddr    = sh_addr_reg;
        mem_wdata    = mem_rdata;

        case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    idx_next = AW'(s_data.index);
                    val_next = s_data.value;
                    ins_next = (s_data.cmd == CMD_INSERT);
                    if (s_data.cmd == CMD_APPEND && !full) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(cnt_reg);
                        mem_wdata = s_data.value;
                        cnt_next  = cnt_reg + CW'(1);
                    end
                    if (s_data.cmd == CMD_INSERT) begin
                        rptr_next = AW'(cnt_reg - CW'(1));
                    end else begin
                        rptr_next = AW'(s_data.index) + AW'(1);
                    end
                end
            end
            ST_SHIFT: begin
                mem_re       = 1'b1;
                sh_pend_next = 1'b1;
                sh_addr_next = ins_reg ? rptr_reg + AW'(1) : rptr_reg - AW'(1);
                rptr_next    = ins_reg ? rptr_reg - AW'(1) : rptr_reg + AW'(1);
            end
            ST_PUT: begin
                if (put_ready) begin
                    if (ins_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = idx_reg;
                        mem_wdata = val_reg;
                        cnt_next  = cnt_reg + CW'(1);
                    end else begin
                        cnt_next  = cnt_reg - CW'(1);
                    end
                    rptr_next = '0;
                end
            end
            ST_READ: begin
                if (rd_issue) begin
                    mem_re       = 1'b1;
                    rd_pend_next = 1'b1;
                    rd_pos_next  = rptr_reg;
                    rd_last_next = rd_is_last;
                    rptr_next    = rptr_reg + AW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        push      = 1'b0;
        push_data = '0;
        if (rd_pend_reg) begin
            push               = 1'b1;
            push_data.word     = mem_rdata;
            push_data.position = POSW'(rd_pos_reg);
            push_data.last     = rd_last_reg;
            push_data.status   = STAT_OK;
        end else if (acc && (err_full || err_range)) begin
            push             = 1'b1;
            push_data.last   = 1'b1;
            push_data.status = err_full ? STAT_FULL : STAT_RANGE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            sh_pend_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            sh_pend_reg <= sh_pend_next;
            rd_pend_reg <= rd_pend_next;
        end
        rptr_reg    <= rptr_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        ins_reg     <= ins_next;
        sh_addr_reg <= sh_addr_next;
        rd_pos_reg  <= rd_pos_next;
        rd_last_reg <= rd_last_next;
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(DEPTH))
        else $error("count exceeds depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        !(sh_pend_reg && rd_pend_reg))
        else $error("shift writeback overlaps readout");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && mem_re) |-> (CW'(rptr_reg) < cnt_reg))
        else $error("readout beyond count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUT && ins_reg && !sh_pend_reg) |-> (mem_waddr == idx_reg))
        else $error("insert word written to wrong entry");

endmodule

/* design/indexed_array_insert_remove_unit.sv */
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | in_t  (cmd, index, value)
// m_      | out       | m_valid / m_ready  | out_t (word, position, last, status)
//
// Append, cmd 3 and rejects finish at accept. Insert/remove: accept, read and write back
// each shifted word, land the last shifted word, put (insert writes the new word), issue
// each readout beat, then queue the last read; insert at index 0 runs longest. Rejects are queued at accept.
// A new item is taken once the last readout beat is queued and the 2-beat queue has room.
// Reset is synchronous on aresetn; it clears the count and control, not the words.
// m_ready low stalls readout issue and, once the queue is full, acceptance; the output queue holds issued beats.
module indexed_array_insert_remove_unit #(
    parameter int DEPTH = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  iair_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output iair_pkg::out_t m_data
);
    import iair_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [WORDW-1:0] mem_wdata;
    logic                    mem_re;
    logic [AW-1:0]           mem_raddr;
    logic signed [WORDW-1:0] mem_rdata;
    oq_stat_t                oq_stat;
    logic                    push;
    out_t                    push_data;

    iair_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .aclk (aclk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .re   (mem_re),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    iair_seq #(
        .DEPTH(DEPTH)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .mem_we   (mem_we),
        .mem_waddr(mem_waddr),
        .mem_wdata(mem_wdata),
        .mem_re   (mem_re),
        .mem_raddr(mem_raddr),
        .mem_rdata(mem_rdata),
        .oq_stat  (oq_stat),
        .push     (push),
        .push_data(push_data)
    );

    iair_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_data(push_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .stat     (oq_stat)
    );

endmodule

/* tb/tb_top.sv */
module tb_top;
    import iair_pkg::*;

    localparam int DEPTH        = 32;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2 * DEPTH + 40;
    localparam int RANDOM_ITEMS = 185;

    localparam logic [CMDW-1:0] CMD_UNUSED = 2'd3;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // Predicted list contents and the result beats still owed by the block
    logic signed [WORDW-1:0] list_words[$];
    out_t                    expected_beats[$];

    int cycle_count = 0;
    int err_count   = 0;
    int items_sent  = 0;
    int beats_seen  = 0;
    int full_rejects  = 0;
    int range_rejects = 0;
    int peak_length   = 0;

    int burst_left = 0;

    logic [15:0] rx_pattern = 16'hffff;
    logic [5:0]  rx_step    = '0;

    indexed_array_insert_remove_unit #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb_top: errors");
        $finish;
    end

    // Receiver: pick a fresh stall pattern each time rx_step wraps, often none at all
    always @(negedge aclk) begin
        if (rx_step == 0) begin
            if ($urandom_range(0, 3) == 0)
                rx_pattern = 16'hffff;
            else
                rx_pattern = 16'($urandom) | 16'h0001;
        end
        m_ready <= rx_pattern[rx_step[3:0]];
        rx_step <= rx_step + 1'b1;
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            beats_seen++;
            if (expected_beats.size() == 0) begin
                $error("unexpected beat: word %0d position %0d last %0b status %0d",
                       m_data.word, m_data.position, m_data.last, m_data.status);
                err_count++;
            end else begin
                want = expected_beats.pop_front();
                if (m_data.word !== want.word) begin
                    $error("word: expected %0d, got %0d", want.word, m_data.word);
                    err_count++;
                end
                if (m_data.position !== want.position) begin
                    $error("position: expected %0d, got %0d",
                           want.position, m_data.position);
                    err_count++;
                end
                if (m_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_data.last);
                    err_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    err_count++;
                end
            end
        end
    end

    function automatic void owe_reject(logic [STATW-1:0] code);
        out_t b;
        b.word     = '0;
        b.position = '0;
        b.last     = 1'b1;
        b.status   = code;
        expected_beats.push_back(b);
        if (code == STAT_FULL)
            full_rejects++;
        else
            range_rejects++;
    endfunction

    function automatic void owe_list_dump();
        out_t b;
        for (int i = 0; i < list_words.size(); i++) begin
            b.word     = list_words[i];
            b.position = POSW'(i);
            b.last     = (i == list_words.size() - 1);
            b.status   = STAT_OK;
            expected_beats.push_back(b);
        end
    endfunction

    // Update the list copy for one accepted command and queue what it owes
    function automatic void apply_command(in_t it);
        int n;
        int idx;
        n   = list_words.size();
        idx = int'(it.index);
        case (it.cmd)
            CMD_APPEND: begin
                if (n >= DEPTH)
                    owe_reject(STAT_FULL);
                else
                    list_words.push_back(it.value);
            end
            CMD_INSERT: begin
                if (n >= DEPTH) begin
                    owe_reject(STAT_FULL);
                end else if (idx > n) begin
                    owe_reject(STAT_RANGE);
                end else begin
                    list_words.insert(idx, it.value);
                    owe_list_dump();
                end
            end
            CMD_REMOVE: begin
                if (idx >= n) begin
                    owe_reject(STAT_RANGE);
                end else begin
                    list_words.delete(idx);
                    owe_list_dump();
                end
            end
            default: ;
        endcase
        if (list_words.size() > peak_length)
            peak_length = list_words.size();
    endfunction

    // Drive one beat, hold it until taken, then maybe close the burst
    task automatic send_item(logic [CMDW-1:0] cmd, int idx, logic [WORDW-1:0] val);
        in_t it;
        it.cmd   = cmd;
        it.index = IDXW'(idx);
        it.value = val;
        @(negedge aclk);
        s_data  <= it;
        s_valid <= 1'b1;
        do
            @(posedge aclk);
        while (s_ready !== 1'b1);
        apply_command(it);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            @(negedge aclk);
            s_valid <= 1'b0;
            if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(10, 80)) @(negedge aclk);
            else
                repeat ($urandom_range(0, 5)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30)
                                                     : $urandom_range(1, 6);
        end
    endtask

    function automatic logic [WORDW-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_list();
        send_item(CMD_REMOVE, 0, 32'h1234_5678);
        send_item(CMD_REMOVE, 63, 32'hffff_ffff);
        send_item(CMD_INSERT, 1, 32'h0000_0001);
        send_item(CMD_UNUSED, 63, 32'hffff_ffff);
        send_item(CMD_INSERT, 0, 32'h7fff_ffff);
        // drop the only word: no readout follows
        send_item(CMD_REMOVE, 0, 32'h0);
    endtask

    task automatic test_insert_at_edges();
        send_item(CMD_APPEND, 0, 32'h8000_0000);
        send_item(CMD_APPEND, 5, 32'h0000_0000);
        send_item(CMD_APPEND, 0, 32'hffff_ffff);
        send_item(CMD_INSERT, list_words.size(), 32'h0000_0001);
        send_item(CMD_INSERT, 0, 32'h5555_5555);
        send_item(CMD_INSERT, 2, 32'haaaa_aaaa);
        send_item(CMD_INSERT, 63, 32'h1);
        send_item(CMD_INSERT, list_words.size() + 1, 32'h2);
    endtask

    task automatic test_remove_at_edges();
        send_item(CMD_REMOVE, list_words.size() - 1, 32'h0);
        send_item(CMD_REMOVE, 0, 32'hffff_ffff);
        send_item(CMD_REMOVE, list_words.size() / 2, 32'h0);
        send_item(CMD_REMOVE, list_words.size(), 32'h0);
        send_item(CMD_REMOVE, 32, 32'h0);
        send_item(CMD_UNUSED, 0, 32'h0);
    endtask

    // Alternate fill and drain phases so full and empty lists both come up
    task automatic test_random_traffic(int target);
        int sent;
        int r;
        int n;
        int idx;
        bit growing;
        logic [CMDW-1:0] cmd;
        sent    = 0;
        growing = 1'b1;
        while (sent < target) begin
            n = list_words.size();
            r = $urandom_range(0, 99);
            if (growing)
                cmd = (r < 45) ? CMD_APPEND : (r < 85) ? CMD_INSERT :
                      (r < 96) ? CMD_REMOVE : CMD_UNUSED;
            else
                cmd = (r < 8) ? CMD_APPEND : (r < 22) ? CMD_INSERT :
                      (r < 96) ? CMD_REMOVE : CMD_UNUSED;
            if ($urandom_range(0, 9) == 0 || cmd == CMD_UNUSED)
                idx = $urandom_range(0, 63);
            else if (cmd == CMD_REMOVE)
                idx = (n > 0) ? $urandom_range(0, n - 1) : $urandom_range(0, 63);
            else
                idx = $urandom_range(0, n);
            send_item(cmd, idx, pick_value());
            if (cmd != CMD_UNUSED)
                sent++;
            n = list_words.size();
            if (growing && n == DEPTH && $urandom_range(0, 2) == 0)
                growing = 1'b0;
            else if (!growing && n == 0 && $urandom_range(0, 1) == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                growing = !growing;
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_list();
        test_insert_at_edges();
        test_remove_at_edges();
        test_random_traffic(RANDOM_ITEMS);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d commands, %0d result beats, peak list length %0d of %0d",
                 items_sent, beats_seen, peak_length, DEPTH);
        $display("rejects seen: %0d list full, %0d index out of range",
                 full_rejects, range_rejects);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
